// File: rtl/core/tfiir_pkg.sv
`default_nettype none
package tfiir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEFF_W    = 16;
  localparam int COEFF_FRAC = 14;
  localparam int ORDER_W    = 2;
  localparam int DEF_ORDER  = 2;
  localparam int NUM_TAPS   = 5;
  localparam int TAP_W      = $clog2(NUM_TAPS);
  localparam int PROD_W     = SAMPLE_W + COEFF_W;
  localparam int ACC_W      = PROD_W + $clog2(NUM_TAPS);
  localparam int QCNT_W     = $clog2(ACC_W);
  localparam int CFG_ADDR_W = 3;
  localparam int SAT_MAX    = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAT_MIN    = -(2 ** (SAMPLE_W - 1));

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ORDER = 3'd0,
    REG_FEED0 = 3'd1,
    REG_FEED1 = 3'd2,
    REG_FEED2 = 3'd3,
    REG_NORM  = 3'd4,
    REG_BACK1 = 3'd5,
    REG_BACK2 = 3'd6
  } cfg_reg_t;

  typedef enum logic [TAP_W-1:0] {
    TAP_FEED0 = 3'd0,
    TAP_FEED1 = 3'd1,
    TAP_BACK1 = 3'd2,
    TAP_FEED2 = 3'd3,
    TAP_BACK2 = 3'd4
  } tap_t;

  typedef struct packed {
    logic load_in;
    logic mac_start;
    logic mul_en;
    tap_t tap;
    logic div_start;
    logic div_step;
    logic finish;
  } tfiir_cmd_t;

  typedef struct packed {
    logic div_last;
  } tfiir_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/transfer_function_iir_filter_unit.sv
// Channel   Direction  Payload
// in_       slave      tdata[15:0] sample_in
// out_      master     tdata[15:0] sample_out; tuser[0] clipped, tuser[1] divide_fault
// cfg_      write      addr = register index, wdata[15:0] register value
//
// From acceptance to its registered result, each request passes through
// five multiply-accumulate steps on one shared multiplier, a drain state,
// a divider load state, a 35-step restoring divider, and a final saturation state.
// No new request is accepted until the cycle after the final state.
// A stalled result holds the block in its final cycle only once a second result waits.
// Reset is synchronous, active low; clears sample history, sets default config.
`default_nettype none
module transfer_function_iir_filter_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [tfiir_pkg::SAMPLE_W-1:0]      in_tdata,   // sample_in
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [tfiir_pkg::SAMPLE_W-1:0]           out_tdata,  // sample_out
  output logic [1:0]                               out_tuser,  // clipped, divide_fault
  input  wire logic                                cfg_wr_en,
  input  wire logic [tfiir_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [tfiir_pkg::COEFF_W-1:0]       cfg_wdata
);
  import tfiir_pkg::*;

  tfiir_cmd_t cmd;
  tfiir_sts_t sts;
  logic       out_clip;
  logic       out_fault;

  tfiir_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tfiir_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_sample (out_tdata),
    .out_clip   (out_clip),
    .out_fault  (out_fault)
  );

  assign out_tuser = {out_fault, out_clip};

endmodule
`default_nettype wire

// File: rtl/core/tfiir_dp.sv
`default_nettype none
module tfiir_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [tfiir_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [tfiir_pkg::COEFF_W-1:0]        cfg_wdata,
  input  wire logic [tfiir_pkg::SAMPLE_W-1:0]       in_sample,
  input  wire tfiir_pkg::tfiir_cmd_t                cmd,
  output tfiir_pkg::tfiir_sts_t                     sts,
  output logic [tfiir_pkg::SAMPLE_W-1:0]            out_sample,
  output logic                                      out_clip,
  output logic                                      out_fault
);
  import tfiir_pkg::*;

  localparam int QW = ACC_W + 1;
  localparam logic signed [QW-1:0] Q_HI = QW'(SAT_MAX);
  localparam logic signed [QW-1:0] Q_LO = QW'(SAT_MIN);

  logic [ORDER_W-1:0]         order_r;
  logic signed [COEFF_W-1:0]  feed0_r, feed1_r, feed2_r, norm_r, back1_r, back2_r;
  logic signed [SAMPLE_W-1:0] x_r, pin0_r, pin1_r, pout0_r, pout1_r;

  logic signed [PROD_W-1:0]   prod_r;
  logic                       prod_vld_r, sub_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic [COEFF_W-1:0]         rem_r, dsr_r;
  logic [ACC_W-1:0]           quo_r;
  logic [QCNT_W-1:0]          cnt_r;
  logic                       neg_r, fault_r;

  logic [SAMPLE_W-1:0]        out_sample_r;
  logic                       out_clip_r, out_fault_r;

  logic signed [COEFF_W-1:0]  mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic                       tap_on, tap_sub;
  logic [ACC_W-1:0]           acc_mag;
  logic [COEFF_W-1:0]         norm_mag;
  logic [COEFF_W:0]           rem_sh, rem_sub;
  logic                       rem_ge;
  logic signed [QW-1:0]       quo_s;
  logic signed [SAMPLE_W-1:0] y_val;
  logic                       y_clip;

  always_comb begin
    mul_a   = feed0_r;
    mul_b   = x_r;
    tap_on  = 1'b1;
    tap_sub = 1'b0;
    unique case (cmd.tap)
      TAP_FEED0: begin
        mul_a = feed0_r;
        mul_b = x_r;
      end
      TAP_FEED1: begin
        mul_a  = feed1_r;
        mul_b  = pin0_r;
        tap_on = (order_r != '0);
      end
      TAP_BACK1: begin
        mul_a   = back1_r;
        mul_b   = pout0_r;
        tap_on  = (order_r != '0);
        tap_sub = 1'b1;
      end
      TAP_FEED2: begin
        mul_a  = feed2_r;
        mul_b  = pin1_r;
        tap_on = order_r[1];
      end
      TAP_BACK2: begin
        mul_a   = back2_r;
        mul_b   = pout1_r;
        tap_on  = order_r[1];
        tap_sub = 1'b1;
      end
      default: tap_on = 1'b0;
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign acc_mag  = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign norm_mag = norm_r[COEFF_W-1] ? COEFF_W'(-norm_r) : COEFF_W'(norm_r);
  assign rem_sh   = {rem_r, quo_r[ACC_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dsr_r};
  assign rem_ge   = (rem_sh >= {1'b0, dsr_r});
  assign quo_s    = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  always_comb begin
    y_val  = '0;
    y_clip = 1'b0;
    priority if (fault_r) begin
      y_val = '0;
    end else if (quo_s > Q_HI) begin
      y_val  = SAMPLE_W'(SAT_MAX);
      y_clip = 1'b1;
    end else if (quo_s < Q_LO) begin
      y_val  = SAMPLE_W'(SAT_MIN);
      y_clip = 1'b1;
    end else begin
      y_val = quo_s[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_W'(DEF_ORDER);
      feed0_r <= COEFF_W'(2 ** COEFF_FRAC);
      feed1_r <= '0;
      feed2_r <= '0;
      norm_r  <= COEFF_W'(2 ** COEFF_FRAC);
      back1_r <= '0;
      back2_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ORDER: order_r <= cfg_wdata[ORDER_W-1:0];
        REG_FEED0: feed0_r <= cfg_wdata;
        REG_FEED1: feed1_r <= cfg_wdata;
        REG_FEED2: feed2_r <= cfg_wdata;
        REG_NORM:  norm_r  <= cfg_wdata;
        REG_BACK1: back1_r <= cfg_wdata;
        REG_BACK2: back2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin0_r  <= '0;
      pin1_r  <= '0;
      pout0_r <= '0;
      pout1_r <= '0;
    end else if (cmd.finish) begin
      if (order_r != '0) begin
        pin1_r  <= pin0_r;
        pout1_r <= pout0_r;
      end
      pin0_r  <= x_r;
      pout0_r <= y_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r <= in_sample;
    end
    if (cmd.mul_en) begin
      prod_r <= tap_on ? mul_p : '0;
      sub_r  <= tap_sub;
    end
    if (cmd.mac_start) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= sub_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
    if (cmd.div_start) begin
      rem_r   <= '0;
      quo_r   <= acc_mag;
      dsr_r   <= norm_mag;
      neg_r   <= acc_r[ACC_W-1] ^ norm_r[COEFF_W-1];
      fault_r <= (norm_r == '0);
      cnt_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sub[COEFF_W-1:0] : rem_sh[COEFF_W-1:0];
      quo_r <= {quo_r[ACC_W-2:0], rem_ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.finish) begin
      out_sample_r <= y_val;
      out_clip_r   <= y_clip;
      out_fault_r  <= fault_r;
    end
  end

  assign sts.div_last = (cnt_r == QCNT_W'(ACC_W - 1));
  assign out_sample   = out_sample_r;
  assign out_clip     = out_clip_r;
  assign out_fault    = out_fault_r;

endmodule
`default_nettype wire

// File: rtl/core/tfiir_ctrl.sv
`default_nettype none
module tfiir_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire tfiir_pkg::tfiir_sts_t sts,
  output tfiir_pkg::tfiir_cmd_t      cmd
);
  import tfiir_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DIV_LOAD,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t             state_r;
  logic [TAP_W-1:0]   tap_r;
  logic               out_tvalid_r;
  logic               out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    cmd           = '0;
    cmd.tap       = tap_t'(tap_r);
    cmd.load_in   = in_tvalid && in_tready;
    cmd.mac_start = in_tvalid && in_tready;
    cmd.mul_en    = (state_r == ST_MAC);
    cmd.div_start = (state_r == ST_DIV_LOAD);
    cmd.div_step  = (state_r == ST_DIV);
    cmd.finish    = (state_r == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tap_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          tap_r <= '0;
          if (in_tvalid) begin
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          tap_r <= tap_r + 1'b1;
          if (tap_r == TAP_W'(NUM_TAPS - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN:    state_r <= ST_DIV_LOAD;
        ST_DIV_LOAD: state_r <= ST_DIV;
        ST_DIV: begin
          if (sts.div_last) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.mul_en, cmd.div_start, cmd.div_step, cmd.finish}))
    else $error("more than one datapath command at once");

  a_accept_to_mac: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> (state_r == ST_MAC) && (tap_r == '0))
    else $error("accepted request did not start the tap sequence");

  a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && sts.div_last |=> (state_r == ST_FIN))
    else $error("divider finished without leaving the divide state");

  a_finish_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten while still held");

endmodule
`default_nettype wire
